// ===== rtl/ilb_pkg.sv =====
// Shared types and codes for the indexed list buffer.
package ilb_pkg;

  localparam int WORD_W  = 32;
  localparam int POS_W   = 6;
  localparam int OP_W    = 3;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  localparam logic signed [WORD_W-1:0] NEG_ONE = -32'sd1;

  typedef enum logic [1:0] {
    MD_HOLD,
    MD_INSERT,
    MD_ERASE
  } ilb_mode_t;

  typedef struct packed {
    ilb_mode_t mode;
    logic      load;
    logic      shift;
  } ilb_ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } ilb_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [STAT_W-1:0]        status;
  } ilb_out_t;

endpackage

// ===== rtl/ilb_cell.sv =====
// One storage cell of the list chain, with its two readout shift stages.
module ilb_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                          clk,
  input  ilb_pkg::ilb_ctrl_t            ctrl,
  input  logic [IDX_W-1:0]              pos,
  input  logic [ilb_pkg::WORD_W-1:0]    value,
  input  logic [ilb_pkg::WORD_W-1:0]    lower,
  input  logic [ilb_pkg::WORD_W-1:0]    upper,
  input  logic [IDX_W-1:0]              rd_idx,
  input  logic [IDX_W-1:0]              bk_idx,
  input  logic [ilb_pkg::WORD_W-1:0]    rd_up,
  input  logic [ilb_pkg::WORD_W-1:0]    bk_up,
  output logic [ilb_pkg::WORD_W-1:0]    data,
  output logic [ilb_pkg::WORD_W-1:0]    rd_car,
  output logic [ilb_pkg::WORD_W-1:0]    bk_car
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [ilb_pkg::WORD_W-1:0] data_r, data_nxt;
  logic [ilb_pkg::WORD_W-1:0] rd_car_r, rd_car_nxt;
  logic [ilb_pkg::WORD_W-1:0] bk_car_r, bk_car_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.mode)
      ilb_pkg::MD_INSERT: begin
        if (MY_IDX == pos) begin
          data_nxt = value;
        end else if (MY_IDX > pos) begin
          data_nxt = lower;
        end
      end
      ilb_pkg::MD_ERASE: begin
        if (MY_IDX >= pos) begin
          data_nxt = upper;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // The bottom cell collects the single selected word; the others pass it down.
  always_comb begin
    rd_car_nxt = rd_car_r;
    bk_car_nxt = bk_car_r;
    if (ctrl.load) begin
      rd_car_nxt = (MY_IDX == rd_idx) ? data_r : '0;
      bk_car_nxt = (MY_IDX == bk_idx) ? data_r : '0;
    end else if (ctrl.shift) begin
      rd_car_nxt = (IDX == 0) ? (rd_car_r | rd_up) : rd_up;
      bk_car_nxt = (IDX == 0) ? (bk_car_r | bk_up) : bk_up;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    rd_car_r <= rd_car_nxt;
    bk_car_r <= bk_car_nxt;
  end

  assign data   = data_r;
  assign rd_car = rd_car_r;
  assign bk_car = bk_car_r;

endmodule

// ===== rtl/indexed_list_buffer_unit.sv =====
// Indexed list buffer: an ordered list of words kept in a chain of cells.
// One word is accepted at a time. The cells insert or erase at the accepting edge itself.
// The load step then copies the popped or read word and the last element into the readout
// chain, the drain steps move them down one cell per cycle to the bottom cell, and the
// finish step registers the result. The next word is taken only after the result is
// registered, so a new word is not accepted while one is in the chain, and a finished
// result that finds the output register still stalled keeps the input stalled too. A
// finished result waits in its own output register while the next word is accepted.
module indexed_list_buffer_unit #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ilb_pkg::ilb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ilb_pkg::ilb_out_t out_data
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int PW   = (CNTW > ilb_pkg::POS_W) ? CNTW : ilb_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                       state_r;
  logic [CNTW-1:0]              cnt_r;
  logic [IW-1:0]                dcnt_r;
  logic [IW-1:0]                rd_idx_r;
  logic                         rdsel_r;
  logic [ilb_pkg::STAT_W-1:0]   status_r;
  logic                         out_valid_r;
  ilb_pkg::ilb_out_t            out_data_r;

  logic                         in_fire;
  logic                         out_load;
  logic [PW-1:0]                pos_w;
  logic [PW-1:0]                cnt_w;
  logic                         full;
  logic                         empty;
  logic [ilb_pkg::STAT_W-1:0]   dec_status;
  ilb_pkg::ilb_mode_t           dec_mode;
  logic [IW-1:0]                dec_pos;
  logic                         dec_rdsel;
  logic [IW-1:0]                dec_rdidx;
  logic [CNTW-1:0]              dec_cnt;
  ilb_pkg::ilb_ctrl_t           ctrl;
  logic [IW-1:0]                bk_idx;

  logic [ilb_pkg::WORD_W-1:0]   data_w [CAPACITY];
  logic [ilb_pkg::WORD_W-1:0]   rd_car_w [CAPACITY+1];
  logic [ilb_pkg::WORD_W-1:0]   bk_car_w [CAPACITY+1];

  logic signed [ilb_pkg::WORD_W-1:0] res_read;
  logic signed [ilb_pkg::WORD_W-1:0] res_front;
  logic signed [ilb_pkg::WORD_W-1:0] res_back;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || !out_stall);
  assign pos_w    = PW'(in_data.position);
  assign cnt_w    = PW'(cnt_r);
  assign full     = (cnt_r == CNTW'(CAPACITY));
  assign empty    = (cnt_r == '0);

  always_comb begin
    dec_status = ilb_pkg::ST_OK;
    dec_mode   = ilb_pkg::MD_HOLD;
    dec_pos    = '0;
    dec_rdsel  = 1'b0;
    dec_rdidx  = '0;
    dec_cnt    = cnt_r;
    unique case (in_data.op)
      ilb_pkg::OP_APPEND: begin
        if (full) begin
          dec_status = ilb_pkg::ST_FULL;
        end else begin
          dec_mode = ilb_pkg::MD_INSERT;
          dec_pos  = IW'(cnt_r);
          dec_cnt  = cnt_r + CNTW'(1);
        end
      end
      ilb_pkg::OP_POP: begin
        if (empty) begin
          dec_status = ilb_pkg::ST_EMPTY;
        end else begin
          dec_rdsel = 1'b1;
          dec_rdidx = IW'(cnt_r - CNTW'(1));
          dec_cnt   = cnt_r - CNTW'(1);
        end
      end
      ilb_pkg::OP_INSERT: begin
        if (full) begin
          dec_status = ilb_pkg::ST_FULL;
        end else if (pos_w > cnt_w) begin
          dec_status = ilb_pkg::ST_BADPOS;
        end else begin
          dec_mode = ilb_pkg::MD_INSERT;
          dec_pos  = IW'(pos_w);
          dec_cnt  = cnt_r + CNTW'(1);
        end
      end
      ilb_pkg::OP_ERASE: begin
        if (empty) begin
          dec_status = ilb_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          dec_status = ilb_pkg::ST_BADPOS;
        end else begin
          dec_mode = ilb_pkg::MD_ERASE;
          dec_pos  = IW'(pos_w);
          dec_cnt  = cnt_r - CNTW'(1);
        end
      end
      ilb_pkg::OP_READ: begin
        if (empty) begin
          dec_status = ilb_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          dec_status = ilb_pkg::ST_BADPOS;
        end else begin
          dec_rdsel = 1'b1;
          dec_rdidx = IW'(pos_w);
        end
      end
      default: begin
        dec_status = ilb_pkg::ST_OK;
      end
    endcase
  end

  assign ctrl.mode  = in_fire ? dec_mode : ilb_pkg::MD_HOLD;
  assign ctrl.load  = (state_r == S_LOAD);
  assign ctrl.shift = (state_r == S_DRAIN);
  assign bk_idx     = IW'(cnt_r - CNTW'(1));

  assign rd_car_w[CAPACITY] = '0;
  assign bk_car_w[CAPACITY] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ilb_pkg::WORD_W-1:0] lower;
      logic [ilb_pkg::WORD_W-1:0] upper;
      if (gi == 0) begin : g_bot
        assign lower = '0;
      end else begin : g_mid_lo
        assign lower = data_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_top
        assign upper = data_w[gi];
      end else begin : g_mid_hi
        assign upper = data_w[gi+1];
      end
      ilb_cell #(
        .IDX_W (IW),
        .IDX   (gi)
      ) u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .pos    (dec_pos),
        .value  (in_data.value),
        .lower  (lower),
        .upper  (upper),
        .rd_idx (rd_idx_r),
        .bk_idx (bk_idx),
        .rd_up  (rd_car_w[gi+1]),
        .bk_up  (bk_car_w[gi+1]),
        .data   (data_w[gi]),
        .rd_car (rd_car_w[gi]),
        .bk_car (bk_car_w[gi])
      );
    end
  endgenerate

  always_comb begin
    if (status_r != ilb_pkg::ST_OK) begin
      res_read = ilb_pkg::NEG_ONE;
    end else if (rdsel_r) begin
      res_read = rd_car_w[0];
    end else begin
      res_read = '0;
    end
    res_front = empty ? ilb_pkg::NEG_ONE : data_w[0];
    res_back  = empty ? ilb_pkg::NEG_ONE : bk_car_w[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cnt_r    <= dec_cnt;
            rd_idx_r <= dec_rdidx;
            rdsel_r  <= dec_rdsel;
            status_r <= dec_status;
            state_r  <= S_LOAD;
          end
        end
        S_LOAD: begin
          dcnt_r  <= IW'(CAPACITY - 1);
          state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (dcnt_r == IW'(1)) begin
            state_r <= S_FINISH;
          end else begin
            dcnt_r <= dcnt_r - IW'(1);
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_data_r.read_value  <= res_read;
            out_data_r.count       <= ilb_pkg::COUNT_W'(cnt_r);
            out_data_r.front_value <= res_front;
            out_data_r.back_value  <= res_back;
            out_data_r.status      <= status_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && dec_status != ilb_pkg::ST_OK) |=> cnt_r == $past(cnt_r))
    else $error("failed request changed the element count");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == ilb_pkg::OP_APPEND && !full)
      |=> cnt_r == $past(cnt_r) + CNTW'(1))
    else $error("append did not grow the list by one");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result word raised outside the finish step");

endmodule
